/* src/btb_pkg.sv */
// Shared types and constants for the branch target buffer predictor.
`default_nettype none
package btb_pkg;
  localparam int unsigned MaxEntries  = 32;
  localparam int unsigned EntryBits   = 5;
  localparam int unsigned MaxHistory  = 8;
  localparam int unsigned TableDepth  = 256;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 5;

  typedef enum logic [1:0] {
    ActPredict = 2'd0,
    ActUpdate  = 2'd1,
    ActInit    = 2'd2,
    ActNone    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    CfgEntriesLog2 = 3'd0,
    CfgHistoryBits = 3'd1,
    CfgTagBits     = 3'd2,
    CfgStartState  = 3'd3,
    CfgGlobalHist  = 3'd4,
    CfgGlobalTable = 3'd5,
    CfgShareMode   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] pc;
    logic [31:0] target_pc;
    logic        taken;
    logic [31:0] predicted_dest;
  } in_word_t;

  typedef struct packed {
    logic        predict_taken;
    logic [31:0] predicted_target;
    logic [31:0] branch_count;
    logic [31:0] flush_count;
  } out_word_t;
endpackage
`default_nettype wire

/* src/btb_if.sv */
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface btb_in_if;
  logic              valid;
  logic              ready;
  btb_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btb_out_if;
  logic               valid;
  logic               ready;
  btb_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/btb_two_level_branch_predictor.sv */
// Top level: direct-mapped BTB with two-level 2-bit counter prediction.
// Predict and update on a hit step through decode, counter read and write back to the result;
// a new word is accepted only once the last one has been written back and the block is idle.
// Allocation refills the entry's 256 counters, one per cycle, before the counter read;
// init refills the shared table likewise; action three passes decode, counter read and write back.
// One word in flight; a waiting result holds the next word before its write back.
// Reset clears valid marks, global history, counts; presets config; local history, counters not reset.
`default_nettype none
module btb_two_level_branch_predictor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  btb_in_if.sink           in_if,
  btb_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [btb_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [btb_pkg::CfgDataBits-1:0] cfg_data_i
);
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFill  = 5'b00010,
    StRead  = 5'b00100,
    StWrite = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  btb_pkg::in_word_t w_q;

  logic [2:0] el2_q;
  logic [3:0] hb_q;
  logic [4:0] tb_q;
  logic [1:0] fss_q, sm_q;
  logic       gh_q, gt_q;

  logic [btb_pkg::MaxEntries-1:0] valid_q;
  logic [29:0] tag_q [btb_pkg::MaxEntries];
  logic [31:0] tgt_q [btb_pkg::MaxEntries];
  logic [7:0]  lhist_q [btb_pkg::MaxEntries];
  logic [7:0]  ghist_q;
  logic [31:0] bcnt_q, fcnt_q;

  logic [1:0] emem [btb_pkg::MaxEntries*btb_pkg::TableDepth];
  logic [1:0] smem [btb_pkg::TableDepth];
  logic [1:0] erd_q, srd_q;

  logic [8:0] fill_q;
  logic       ovalid_q;
  btb_pkg::out_word_t odata_q;

  logic [2:0]  el2;
  logic [3:0]  hb;
  logic [7:0]  hmask;
  logic [4:0]  slot;
  logic [29:0] tmask, tag;
  logic        hit;
  logic [7:0]  hsel, sidx;
  logic [12:0] eaddr;
  logic [1:0]  ctr, ctr_n;
  logic [31:0] seq;
  logic        pred_tk, flush;
  logic [31:0] bcnt_d, fcnt_d;

  always_comb begin
    el2 = (el2_q > 3'd5) ? 3'd5 : el2_q;
    hb = (hb_q == 4'd0) ? 4'd1 : ((hb_q > 4'd8) ? 4'd8 : hb_q);
    hmask = 8'((9'd1 << hb) - 9'd1);
    slot = 5'((w_q.pc >> 2) & ((32'd1 << el2) - 32'd1));
    tmask = 30'(((31'd1 << ((tb_q > 5'd30) ? 5'd30 : tb_q)) - 31'd1));
    tag = 30'(w_q.pc >> (el2 + 3'd2)) & tmask;
    hit = valid_q[slot] && (tag_q[slot] == tag);
    hsel = (gh_q ? ghist_q : lhist_q[slot]) & hmask;
    case (sm_q)
      2'd1:    sidx = hsel ^ (w_q.pc[9:2] & hmask);
      2'd2:    sidx = hsel ^ (w_q.pc[23:16] & hmask);
      default: sidx = hsel;
    endcase
    eaddr = {slot, hsel};
    ctr = gt_q ? srd_q : erd_q;
    ctr_n = w_q.taken ? ((ctr == 2'd3) ? ctr : ctr + 2'd1)
                      : ((ctr == 2'd0) ? ctr : ctr - 2'd1);
    seq = w_q.pc + 32'd4;
    pred_tk = (w_q.action == btb_pkg::ActPredict) && hit && ctr[1];
    flush = (w_q.taken && w_q.predicted_dest != w_q.target_pc) ||
            (!w_q.taken && w_q.predicted_dest != seq);
    bcnt_d = bcnt_q;
    fcnt_d = fcnt_q;
    case (w_q.action)
      btb_pkg::ActUpdate: begin
        bcnt_d = bcnt_q + 32'd1;
        if (flush) fcnt_d = fcnt_q + 32'd1;
      end
      btb_pkg::ActInit: begin
        bcnt_d = 32'd0;
        fcnt_d = 32'd0;
      end
      default: ;
    endcase
  end

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = ovalid_q;
  assign out_if.data = odata_q;

  wire in_acc = in_if.valid && in_if.ready;
  wire fill_last = (fill_q[7:0] == 8'hff);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_acc) state_d = StDone;
      StDone: begin
        if (w_q.action == btb_pkg::ActInit) state_d = StFill;
        else if (w_q.action == btb_pkg::ActUpdate && !hit) state_d = StFill;
        else state_d = StRead;
      end
      StFill:  if (fill_last) state_d = StRead;
      StRead:  if (!ovalid_q || out_if.ready) state_d = StWrite;
      StWrite: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFill) begin
      if (w_q.action == btb_pkg::ActInit) smem[fill_q[7:0]] <= fss_q;
      else emem[{slot, fill_q[7:0]}] <= fss_q;
    end else if (state_q == StWrite && w_q.action == btb_pkg::ActUpdate) begin
      if (gt_q) smem[sidx] <= ctr_n;
      else emem[eaddr] <= ctr_n;
    end
    erd_q <= emem[eaddr];
    srd_q <= smem[sidx];
    if (in_acc) w_q <= in_if.data;
    if (state_q == StDone && w_q.action == btb_pkg::ActUpdate && !hit) begin
      tag_q[slot] <= tag;
      lhist_q[slot] <= 8'd0;
    end
    if (state_q == StWrite && w_q.action == btb_pkg::ActUpdate) begin
      tgt_q[slot] <= w_q.target_pc;
      if (!gh_q) lhist_q[slot] <= {hsel[6:0], w_q.taken} & hmask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      el2_q <= 3'd5; hb_q <= 4'd8; tb_q <= 5'd30; fss_q <= 2'd1;
      gh_q <= 1'b0; gt_q <= 1'b0; sm_q <= 2'd0;
      valid_q <= '0; ghist_q <= '0; bcnt_q <= '0; fcnt_q <= '0;
      fill_q <= '0; ovalid_q <= 1'b0; odata_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          btb_pkg::CfgEntriesLog2: el2_q <= cfg_data_i[2:0];
          btb_pkg::CfgHistoryBits: hb_q <= cfg_data_i[3:0];
          btb_pkg::CfgTagBits:     tb_q <= cfg_data_i;
          btb_pkg::CfgStartState:  fss_q <= cfg_data_i[1:0];
          btb_pkg::CfgGlobalHist:  gh_q <= cfg_data_i[0];
          btb_pkg::CfgGlobalTable: gt_q <= cfg_data_i[0];
          btb_pkg::CfgShareMode:   sm_q <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (state_q == StWrite) ovalid_q <= 1'b1;
      else if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      fill_q <= (state_q == StFill) ? fill_q + 9'd1 : 9'd0;
      if (state_q == StDone && w_q.action == btb_pkg::ActUpdate && !hit)
        valid_q[slot] <= 1'b1;
      if (state_q == StWrite) begin
        odata_q.predict_taken <= pred_tk;
        odata_q.predicted_target <= pred_tk ? tgt_q[slot] :
            ((w_q.action == btb_pkg::ActPredict) ? seq : 32'd0);
        odata_q.branch_count <= bcnt_d;
        odata_q.flush_count <= fcnt_d;
        bcnt_q <= bcnt_d;
        fcnt_q <= fcnt_d;
        if (w_q.action == btb_pkg::ActUpdate && gh_q)
          ghist_q <= {hsel[6:0], w_q.taken} & hmask;
        if (w_q.action == btb_pkg::ActInit) begin
          valid_q <= '0;
          ghist_q <= '0;
        end
      end
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> (state_q == StIdle)) else $error("ready outside idle");
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> ovalid_q) else $error("result lost");
  a_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && w_q.action == btb_pkg::ActUpdate) |=> valid_q[$past(slot)])
    else $error("entry not allocated");
`endif
endmodule
`default_nettype wire
